FILE: rtl/dqs_pkg.sv
// shared types for the deque-with-search block: cell operations,
// slot contents and the search wave passed along the cell chain
`timescale 1ns / 1ps
`default_nettype none
package dqs_pkg;

  localparam int unsigned WORD_W = 32;

  // what every cell does at each clock edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHR,    // push front: take left neighbor
    CELL_SHL,    // pop front: take right neighbor
    CELL_PUSHB,  // push back: first empty cell loads the word
    CELL_POPB    // pop back: last held cell drops its entry
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [WORD_W-1:0] word;  // word to push or key to search for
  } cell_ctrl_t;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] data;
  } slot_t;

  // front-to-back wave: match seen so far and last held entry seen so far
  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] last;
  } wave_t;

endpackage
`default_nettype wire

FILE: rtl/dqs_cell.sv
// one deque cell: holds a single entry and its valid bit, moves it to or
// from its neighbors, and advances the search wave by one position per cycle
// depends on dqs_pkg
`timescale 1ns / 1ps
`default_nettype none
module dqs_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  dqs_pkg::cell_ctrl_t     ctrl,
  input  dqs_pkg::slot_t          left_i,
  input  dqs_pkg::slot_t          right_i,
  output dqs_pkg::slot_t          slot_o,
  input  dqs_pkg::wave_t          wave_i,
  output dqs_pkg::wave_t          wave_o,
  output dqs_pkg::wave_t          wave_nxt_o
);

  logic                         vld_r;
  logic                         vld_nxt;
  logic [dqs_pkg::WORD_W-1:0]   data_r;
  logic [dqs_pkg::WORD_W-1:0]   data_nxt;
  dqs_pkg::wave_t               wave_r;
  dqs_pkg::wave_t               wave_nxt;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    case (ctrl.op)
      dqs_pkg::CELL_SHR: begin
        vld_nxt  = left_i.vld;
        data_nxt = left_i.data;
      end
      dqs_pkg::CELL_SHL: begin
        vld_nxt  = right_i.vld;
        data_nxt = right_i.data;
      end
      dqs_pkg::CELL_PUSHB: begin
        if (!vld_r && left_i.vld) begin
          vld_nxt  = 1'b1;
          data_nxt = ctrl.word;
        end
      end
      dqs_pkg::CELL_POPB: begin
        if (vld_r && !right_i.vld) begin
          vld_nxt = 1'b0;
        end
      end
      default: begin
        vld_nxt  = vld_r;
        data_nxt = data_r;
      end
    endcase
  end

  always_comb begin
    wave_nxt.found = wave_i.found | (vld_r & (data_r == ctrl.word));
    wave_nxt.last  = vld_r ? data_r : wave_i.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    data_r <= data_nxt;
    wave_r <= wave_nxt;
  end

  assign slot_o.vld  = vld_r;
  assign slot_o.data = data_r;
  assign wave_o      = wave_r;
  assign wave_nxt_o  = wave_nxt;

endmodule
`default_nettype wire

FILE: rtl/double_ended_queue_with_search_core.sv
// Bounded deque of DEPTH signed 32-bit words with a membership search, built
// as a row of DEPTH cells with the front entry in the first cell. Pushes at
// either end, pops from the front and all commands that fail or do nothing
// complete in the idle state. A pop from the back and a search on a non-empty
// deque walk a wave along the cell row one cell per cycle, collecting the
// match flag and the last held entry. One command is in work at a time. A
// new one is taken only once the output register is free, that is when no
// result is held there or when the held result leaves at the same edge.
// depends on dqs_pkg and dqs_cell
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_with_search_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   in_cmd,
  input  wire logic signed [31:0]           in_data_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic signed [31:0]                out_data_out,
  output logic [$clog2(DEPTH+1)-1:0]        out_count_after
);

  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam int unsigned CW = $clog2(DEPTH);

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_BACK   = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_SEARCH     = 3'd4;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_EMPTY    = 2'd1;
  localparam logic [1:0] STS_FULL     = 2'd2;
  localparam logic [1:0] STS_NOTFOUND = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [NW-1:0]                count_r, count_nxt;
  logic                         pend_pop_r, pend_pop_nxt;
  logic [dqs_pkg::WORD_W-1:0]   key_r, key_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic [dqs_pkg::WORD_W-1:0]   dout_r, dout_nxt;
  logic [NW-1:0]                cnt_out_r, cnt_out_nxt;

  dqs_pkg::cell_ctrl_t          ctrl;
  dqs_pkg::slot_t               slots [DEPTH];
  dqs_pkg::wave_t               waves [DEPTH];
  dqs_pkg::wave_t               wnxt  [DEPTH];
  dqs_pkg::wave_t               wave_end;

  logic out_free;
  logic accept;
  logic is_full;
  logic is_empty;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == NW'(DEPTH));
  assign is_empty = (count_r == '0);

  // cell row: cell 0 holds the front entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dqs_pkg::slot_t left_s;
    dqs_pkg::slot_t right_s;
    dqs_pkg::wave_t wave_in_s;

    if (i == 0) begin : g_first
      assign left_s.vld   = 1'b1;
      assign left_s.data  = ctrl.word;
      assign wave_in_s    = '0;
    end else begin : g_mid
      assign left_s    = slots[i-1];
      assign wave_in_s = waves[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_s  = '0;
      assign wave_end = wnxt[i];
    end else begin : g_inner
      assign right_s = slots[i+1];
    end

    dqs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_i     (left_s),
      .right_i    (right_s),
      .slot_o     (slots[i]),
      .wave_i     (wave_in_s),
      .wave_o     (waves[i]),
      .wave_nxt_o (wnxt[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    count_nxt     = count_r;
    pend_pop_nxt  = pend_pop_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    dout_nxt      = dout_r;
    cnt_out_nxt   = cnt_out_r;
    ctrl.op       = dqs_pkg::CELL_HOLD;
    ctrl.word     = (state_r == ST_WALK) ? key_r : in_data_in;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          status_nxt    = STS_OK;
          dout_nxt      = '0;
          out_valid_nxt = 1'b1;
          case (in_cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = STS_FULL;
              end else begin
                ctrl.op   = (in_cmd == CMD_PUSH_BACK) ? dqs_pkg::CELL_PUSHB
                                                      : dqs_pkg::CELL_SHR;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty) begin
                status_nxt = STS_EMPTY;
              end else begin
                ctrl.op   = dqs_pkg::CELL_SHL;
                dout_nxt  = slots[0].data;
                count_nxt = count_r - 1'b1;
              end
            end
            CMD_POP_BACK, CMD_SEARCH: begin
              if (is_empty) begin
                status_nxt = STS_EMPTY;
              end else begin
                // result comes after the wave has crossed the row
                out_valid_nxt = 1'b0;
                state_nxt     = ST_WALK;
                cnt_nxt       = '0;
                pend_pop_nxt  = (in_cmd == CMD_POP_BACK);
                key_nxt       = in_data_in;
              end
            end
            default: begin
              status_nxt = STS_OK;
            end
          endcase
          cnt_out_nxt = count_nxt;
        end
      end
      ST_WALK: begin
        if (cnt_r == CW'(DEPTH - 1)) begin
          if (out_free) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            if (pend_pop_r) begin
              ctrl.op    = dqs_pkg::CELL_POPB;
              status_nxt = STS_OK;
              dout_nxt   = wave_end.last;
              count_nxt  = count_r - 1'b1;
            end else begin
              status_nxt = wave_end.found ? STS_OK : STS_NOTFOUND;
              dout_nxt   = '0;
            end
            cnt_out_nxt = count_nxt;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      pend_pop_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      pend_pop_r  <= pend_pop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r     <= key_nxt;
    status_r  <= status_nxt;
    dout_r    <= dout_nxt;
    cnt_out_r <= cnt_out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_data_out    = signed'(dout_r);
  assign out_count_after = cnt_out_r;

endmodule
`default_nettype wire

FILE: dv/deque_search_checker.sv
// command and status codes plus the result checker for the deque-with-search block;
// the checker keeps its own deque, predicts each result and compares; needs the clock and reset
`timescale 1ns / 1ps
package dqs_tb_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_UNUSED5    = 3'd5,
    CMD_UNUSED6    = 3'd6,
    CMD_UNUSED7    = 3'd7
  } dq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } dq_status_e;

endpackage

module deque_search_checker
  import dqs_tb_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [2:0]                 in_cmd,
  input  logic [31:0]                in_data_in,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [1:0]                 out_status,
  input  logic [31:0]                out_data_out,
  input  logic [$clog2(DEPTH+1)-1:0] out_count_after,
  output int                         mismatches,
  output int                         pending
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef struct packed {
    dq_status_e    status;
    logic [31:0]   popped;
    logic [CW-1:0] count;
  } deque_result_t;

  logic [31:0]   ring_words [DEPTH];
  int unsigned   head_pos;
  int unsigned   held;
  deque_result_t results_due [$];

  // applies one command to the local deque and returns what the block must answer
  function automatic deque_result_t deque_step(dq_cmd_e cmd, logic [31:0] word);
    deque_result_t r;
    int unsigned   k;
    r.status = ST_OK;
    r.popped = '0;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (held == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_words[(head_pos + held) % DEPTH] = word;
          held++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (held == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_pos = (head_pos + DEPTH - 1) % DEPTH;
          ring_words[head_pos] = word;
          held++;
        end
      end
      CMD_POP_BACK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = ring_words[(head_pos + held - 1) % DEPTH];
          held--;
        end
      end
      CMD_POP_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = ring_words[head_pos];
          head_pos = (head_pos + 1) % DEPTH;
          held--;
        end
      end
      CMD_SEARCH: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOT_FOUND;
          for (k = 0; k < held; k++) begin
            if (ring_words[(head_pos + k) % DEPTH] == word) begin
              r.status = ST_OK;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = CW'(held);
    return r;
  endfunction

  always @(posedge clk) begin : track
    deque_result_t want;
    if (!rst_n) begin
      head_pos = 0;
      held = 0;
      results_due.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      // queue the new expectation first so a same-edge result still pairs in order
      if (in_valid && in_ready) begin
        results_due.push_back(deque_step(dq_cmd_e'(in_cmd), in_data_in));
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $error("out: result transfer with no command waiting");
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status) begin
            mismatches++;
            $error("out_status: expected %0d, got %0d", want.status, out_status);
          end
          if (out_data_out !== want.popped) begin
            mismatches++;
            $error("out_data_out: expected %0d, got %0d", $signed(want.popped),
                   $signed(out_data_out));
          end
          if (out_count_after !== want.count) begin
            mismatches++;
            $error("out_count_after: expected %0d, got %0d", want.count, out_count_after);
          end
        end
      end
      pending <= results_due.size();
    end
  end

endmodule

FILE: dv/tb_double_ended_queue_with_search_core.sv
// top of the deque-with-search testbench: clock, reset, command stimulus, result
// draining and the verdict; depends on deque_search_checker.sv and the block's rtl
`timescale 1ns / 1ps
module tb_double_ended_queue_with_search_core;
  import dqs_tb_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1620;
  localparam int IDLE_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_cmd;
  logic signed [31:0] in_data_in;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic signed [31:0] out_data_out;
  logic [CW-1:0]      out_count_after;

  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  logic [31:0] recent_words [8] = '{default: '0};
  int unsigned recent_wr = 0;

  always #1 clk = ~clk;

  double_ended_queue_with_search_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_count_after(out_count_after)
  );

  deque_search_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_count_after(out_count_after),
    .mismatches     (fail_count),
    .pending        (pending)
  );

  // valid is only lowered when a gap follows, so it never toggles within one step
  task automatic send_command(dq_cmd_e cmd, logic [31:0] word);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      tx_quiet = !tx_quiet;
    end
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_data_in <= word;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT) begin
      recent_words[recent_wr % 8] = word;
      recent_wr++;
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // small values and recent pushes give duplicates and search hits
  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      return 32'($urandom_range(0, 15));
    end else if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end else if (r < 65) begin
      return recent_words[$urandom_range(0, 7)];
    end
    return $urandom();
  endfunction

  initial begin : drain_results
    int stall;
    out_ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        rx_quiet = !rx_quiet;
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
        $display("** double_ended_queue_with_search_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          n;
    int          mode_left;
    int unsigned push_pct;
    int unsigned r;
    dq_cmd_e     cmd;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_cmd     <= CMD_PUSH_BACK;
    in_data_in <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty deque: both pops and a search report empty, unused commands do nothing
    send_command(CMD_POP_BACK, $urandom());
    send_command(CMD_POP_FRONT, $urandom());
    send_command(CMD_SEARCH, 32'h0000_0000);
    send_command(CMD_UNUSED5, $urandom());
    send_command(CMD_UNUSED6, $urandom());
    send_command(CMD_UNUSED7, $urandom());

    // fill to the top from both ends, extremes first
    send_command(CMD_PUSH_BACK, 32'h7fff_ffff);
    send_command(CMD_PUSH_FRONT, 32'h8000_0000);
    send_command(CMD_PUSH_BACK, 32'h0000_0000);
    send_command(CMD_PUSH_FRONT, 32'hffff_ffff);
    for (n = 0; n < DEPTH - 4; n++) begin
      send_command(n[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom());
    end

    // full deque drops pushes at either end; then two searches and a pop from each end
    send_command(CMD_PUSH_BACK, 32'h1234_5678);
    send_command(CMD_PUSH_FRONT, 32'h1234_5678);
    send_command(CMD_SEARCH, 32'h8000_0000);
    send_command(CMD_SEARCH, 32'h0000_1234);
    send_command(CMD_POP_BACK, $urandom());
    send_command(CMD_POP_FRONT, $urandom());

    // random part: fill-heavy, drain-heavy and balanced stretches
    mode_left = 0;
    push_pct  = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 149) == 0) begin
        hold_until_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        cmd = dq_cmd_e'($urandom_range(5, 7));
      end else if (r < 23) begin
        cmd = CMD_SEARCH;
      end else if ($urandom_range(0, 99) < push_pct) begin
        cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end
      send_command(cmd, pick_word());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a late stray result would still be caught here
    repeat (2 * DEPTH) @(posedge clk);
    if (fail_count == 0) begin
      $display("** double_ended_queue_with_search_core: PASSED **");
    end else begin
      $display("** double_ended_queue_with_search_core: FAILED **");
    end
    $finish;
  end

endmodule
